>>> rtl/equirect_distance_meters_macros.svh
// Assertion shorthands used by the top block to check itself.
// Each one samples on the rising edge of clk and is off while rst_n is low.
`ifndef EQUIRECT_DISTANCE_METERS_MACROS_SVH
`define EQUIRECT_DISTANCE_METERS_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define EDM_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define EDM_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/edm_pkg.sv
`default_nettype none

package edm_pkg;

  // Field widths of a request and of a result.
  localparam int LAT_W   = 31;
  localparam int LON_W   = 32;
  localparam int IN_W    = 128;
  localparam int DIST_W  = 25;
  localparam int OUT_W   = 32;

  // Internal widths, each sized for the largest value it can carry.
  localparam int DLAT_W  = 32;  // lat2 - lat1, signed
  localparam int DLON_W  = 32;  // wrapped longitude difference, signed
  localparam int MEAN_W  = 31;  // sum of halved latitudes, signed
  localparam int AY_W    = 32;  // |dlat| up to 2^31
  localparam int ADLON_W = 31;  // |dlon| up to 1.8e9
  localparam int MAG_W   = 31;  // |mean| up to 2^30
  localparam int DEG_W   = 7;   // whole degrees, at most 107 before the clamp
  localparam int IDX_W   = 4;
  localparam int FRAC_W  = 4;
  localparam int COS_W   = 14;
  localparam int Q_W     = 18;  // |dlon| / 10000
  localparam int R_W     = 14;  // |dlon| % 10000
  localparam int RC_W    = 27;
  localparam int QC_W    = 31;
  localparam int AX_W    = 31;
  localparam int SUM_W   = 63;
  localparam int RAD_W   = 64;
  localparam int ROOT_W  = 32;

  // Longitude wrap limits in 1e-7 degree.
  localparam logic signed [32:0] HALF_TURN = 33'sd1800000000;
  localparam logic signed [32:0] FULL_TURN = 33'sd3600000000;

  localparam logic [DEG_W-1:0] DEG_CLAMP  = 7'd90;
  localparam logic [31:0]      COS_SCALE  = 32'd10000;
  localparam int               TABLE_LAST = 9;

  // Division of the mean latitude by 1e7: exact for magnitudes up to 2^30.
  localparam int          DEG_SHIFT   = 53;
  localparam logic [63:0] DEG_RECIP_F = ((64'd1 << DEG_SHIFT) + 64'd9999999) / 64'd10000000;
  localparam int          DEG_RECIP_W = 30;
  localparam logic [DEG_RECIP_W-1:0] DEG_RECIP = DEG_RECIP_F[DEG_RECIP_W-1:0];

  // Division of |dlon| by 10000: exact below 2^31.
  localparam int          Q_SHIFT   = 45;
  localparam logic [63:0] Q_RECIP_F = ((64'd1 << Q_SHIFT) + 64'd9999) / 64'd10000;
  localparam int          Q_RECIP_W = 32;
  localparam logic [Q_RECIP_W-1:0] Q_RECIP = Q_RECIP_F[Q_RECIP_W-1:0];

  // Division of remainder times cosine by 10000: exact below 1e8.
  localparam int          R_SHIFT   = 40;
  localparam logic [63:0] R_RECIP_F = ((64'd1 << R_SHIFT) + 64'd9999) / 64'd10000;
  localparam int          R_RECIP_W = 27;
  localparam logic [R_RECIP_W-1:0] R_RECIP = R_RECIP_F[R_RECIP_W-1:0];

  // Division of an interpolation step by ten: exact below 16384.
  localparam int                TEN_SHIFT = 16;
  localparam logic [12:0]       TEN_RECIP = 13'd6554;
  localparam int                STEP_W    = 11;

  // Meters scale 111195 / 1e7, reduced to 22239 / 2000000. The rounded-up
  // reciprocal keeps the floor exact for any 32-bit root.
  localparam int           SCALE_SHIFT   = 53;
  localparam logic [127:0] SCALE_RECIP_F =
    ((128'd22239 << SCALE_SHIFT) + 128'd1999999) / 128'd2000000;
  localparam int           SCALE_LO_W    = 24;
  localparam int           SCALE_HI_W    = 23;
  localparam logic [SCALE_LO_W-1:0] SCALE_LO = SCALE_RECIP_F[SCALE_LO_W-1:0];
  localparam logic [SCALE_HI_W-1:0] SCALE_HI =
    SCALE_RECIP_F[SCALE_LO_W +: SCALE_HI_W];
  localparam int           SCALE_SUM_W   = 80;

  // One queued request after the longitude wrap and the latitude halving.
  typedef struct packed {
    logic [DLAT_W-1:0] dlat;
    logic [DLON_W-1:0] dlon;
    logic [MEAN_W-1:0] mean;
  } edm_item_t;

  // Queue status seen by both sides.
  typedef struct packed {
    logic empty;
    logic full;
  } edm_qstat_t;

  // Cosine at 10-degree steps, scale 10000.
  function automatic logic [COS_W-1:0] edm_cos_point(input logic [IDX_W-1:0] idx);
    logic [COS_W-1:0] c;
    case (idx)
      4'd0:    c = 14'd10000;
      4'd1:    c = 14'd9848;
      4'd2:    c = 14'd9396;
      4'd3:    c = 14'd8660;
      4'd4:    c = 14'd7660;
      4'd5:    c = 14'd6427;
      4'd6:    c = 14'd5000;
      4'd7:    c = 14'd3420;
      4'd8:    c = 14'd1736;
      default: c = 14'd0;
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

>>> rtl/equirect_distance_meters.sv
// Approximate distance in whole meters between two points given in 1e-7
// degree. A request is taken in any cycle in which the queue behind the
// input has room, and the block delivers one result per cycle while the
// output side keeps taking them. A request passes through nine stages for
// the cosine of the mean latitude, the scaled longitude and the sum of
// squares (the first loads from the head of the queue), 32 stages of square
// root at one result bit per stage, and two for the meters scale and the
// result register. A stalled output holds the whole back pipeline; the
// queue (QUEUE_DEPTH requests) keeps accepting until it is full.
`default_nettype none

`include "equirect_distance_meters_macros.svh"

module equirect_distance_meters
  import edm_pkg::*;
#(
  parameter int QUEUE_DEPTH = 4
)
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  // first_latitude[30:0], first_longitude[62:31], second_latitude[93:63],
  // second_longitude[125:94], zero fill [127:126]
  input  logic [IN_W-1:0]   in_tdata,
  output logic              out_tvalid,
  input  logic              out_tready,
  // distance_meters[24:0], zero fill [31:25]
  output logic [OUT_W-1:0]  out_tdata
);

  localparam logic [DIST_W-1:0] DIST_LIMIT = 25'd31300000;

  edm_item_t         front_item;
  edm_item_t         head_item;
  edm_qstat_t        q_stat;
  logic              push;
  logic              pop;
  logic [DIST_W-1:0] distance;

  assign in_tready = !q_stat.full;
  assign push      = in_tvalid && in_tready;

  // Front: wrap and halving on the incoming request.
  edm_front u_front (
    .in_data (in_tdata),
    .item    (front_item)
  );

  edm_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_item (front_item),
    .pop       (pop),
    .head_item (head_item),
    .stat      (q_stat)
  );

  edm_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head_item (head_item),
    .q_stat    (q_stat),
    .pop       (pop),
    .out_valid (out_tvalid),
    .out_dist  (distance),
    .out_ready (out_tready)
  );

  assign out_tdata = {{(OUT_W - DIST_W){1'b0}}, distance};

  // Checks on the queue hand-off and on the result range.
  `EDM_ASSERT_NOW(a_pop_not_empty, pop, !q_stat.empty, "pop from an empty queue")
  `EDM_ASSERT_NEXT(a_push_fills, push, !q_stat.empty, "accepted request not queued")
  `EDM_ASSERT_NOW(a_stall_no_pop, out_tvalid && !out_tready, !pop, "pop while output stalled")
  `EDM_ASSERT_NOW(a_dist_range, out_tvalid, distance <= DIST_LIMIT, "distance out of range")

endmodule

`default_nettype wire

>>> rtl/edm_front.sv
`default_nettype none

// Unpacks a request, wraps the longitude difference once into +/-180
// degrees and forms the sum of the latitudes halved toward zero.
module edm_front
  import edm_pkg::*;
(
  input  logic [IN_W-1:0] in_data,
  output edm_item_t       item
);

  logic [LAT_W-1:0]        lat1;
  logic [LON_W-1:0]        lon1;
  logic [LAT_W-1:0]        lat2;
  logic [LON_W-1:0]        lon2;
  logic signed [32:0]      dlon_raw;
  logic signed [32:0]      dlon_sub;
  logic signed [32:0]      dlon_add;
  logic signed [32:0]      dlon_wrap;
  logic [LAT_W-1:0]        lat1_adj;
  logic [LAT_W-1:0]        lat2_adj;
  logic [MEAN_W-1:0]       half1;
  logic [MEAN_W-1:0]       half2;

  assign lat1 = in_data[30:0];
  assign lon1 = in_data[62:31];
  assign lat2 = in_data[93:63];
  assign lon2 = in_data[125:94];

  // Latitude difference fits 32 bits signed.
  assign item.dlat = {lat2[LAT_W-1], lat2} - {lat1[LAT_W-1], lat1};

  // Longitude difference with a single wrap; all three candidates in parallel.
  assign dlon_raw = $signed({lon2[LON_W-1], lon2}) - $signed({lon1[LON_W-1], lon1});
  assign dlon_sub = dlon_raw - FULL_TURN;
  assign dlon_add = dlon_raw + FULL_TURN;

  always_comb begin
    if (dlon_raw > HALF_TURN) begin
      dlon_wrap = dlon_sub;
    end else if (dlon_raw < -HALF_TURN) begin
      dlon_wrap = dlon_add;
    end else begin
      dlon_wrap = dlon_raw;
    end
  end

  assign item.dlon = dlon_wrap[DLON_W-1:0];

  // Halving toward zero: add one to a negative value, then shift arithmetically.
  assign lat1_adj = lat1 + LAT_W'(lat1[LAT_W-1]);
  assign lat2_adj = lat2 + LAT_W'(lat2[LAT_W-1]);
  assign half1    = {lat1_adj[LAT_W-1], lat1_adj[LAT_W-1:1]};
  assign half2    = {lat2_adj[LAT_W-1], lat2_adj[LAT_W-1:1]};
  assign item.mean = half1 + half2;

endmodule

`default_nettype wire

>>> rtl/edm_queue.sv
`default_nettype none

// Short register queue between the front and the back part.
module edm_queue
  import edm_pkg::*;
#(
  parameter int DEPTH = 4
)
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  edm_item_t  push_item,
  input  logic       pop,
  output edm_item_t  head_item,
  output edm_qstat_t stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  edm_item_t        entry_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  assign stat.empty = (count_r == '0);
  assign stat.full  = (count_r == CNT_W'(DEPTH));
  assign head_item  = entry_r[rd_ptr_r];

  // Pointer and fill count update.
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
    end
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  // Entry storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

`default_nettype wire

>>> rtl/edm_sqrt.sv
`default_nettype none

// Pipelined floor square root: one result bit per stage, 32 stages.
module edm_sqrt
  import edm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  logic              adv,
  input  logic              in_valid,
  input  logic [RAD_W-1:0]  rad,
  output logic              root_valid,
  output logic [ROOT_W-1:0] root
);

  localparam int STAGES = ROOT_W;
  localparam int REM_W  = ROOT_W + 3;

  logic [REM_W-1:0]  rem_r  [STAGES];
  logic [ROOT_W-1:0] root_r [STAGES];
  logic [RAD_W-1:0]  rad_r  [STAGES];
  logic              vld_r  [STAGES];

  for (genvar i = 0; i < STAGES; i++) begin : g_stage
    logic [REM_W-1:0]  rem_in;
    logic [ROOT_W-1:0] root_in;
    logic [RAD_W-1:0]  rad_in;
    logic              vld_in;
    logic [REM_W-1:0]  cand;
    logic [REM_W-1:0]  trial;
    logic [REM_W-1:0]  rem_nxt;
    logic [ROOT_W-1:0] root_nxt;

    if (i == 0) begin : g_first
      assign rem_in  = '0;
      assign root_in = '0;
      assign rad_in  = rad;
      assign vld_in  = in_valid;
    end else begin : g_next
      assign rem_in  = rem_r[i-1];
      assign root_in = root_r[i-1];
      assign rad_in  = rad_r[i-1];
      assign vld_in  = vld_r[i-1];
    end

    // Bring down two radicand bits and try 4*root + 1.
    assign cand  = {rem_in[REM_W-3:0], rad_in[RAD_W-1 -: 2]};
    assign trial = {1'b0, root_in, 2'b01};

    always_comb begin
      if (cand >= trial) begin
        rem_nxt  = cand - trial;
        root_nxt = {root_in[ROOT_W-2:0], 1'b1};
      end else begin
        rem_nxt  = cand;
        root_nxt = {root_in[ROOT_W-2:0], 1'b0};
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[i] <= 1'b0;
      end else if (adv) begin
        vld_r[i] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        rem_r[i]  <= rem_nxt;
        root_r[i] <= root_nxt;
        rad_r[i]  <= {rad_in[RAD_W-3:0], 2'b00};
      end
    end
  end

  assign root_valid = vld_r[STAGES-1];
  assign root       = root_r[STAGES-1];

endmodule

`default_nettype wire

>>> rtl/edm_back.sv
`default_nettype none

// Back part: cosine of the mean latitude, scaled longitude, sum of squares,
// square root and meters scale. The whole pipeline holds while the result
// register waits to be taken.
module edm_back
  import edm_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  input  edm_item_t         head_item,
  input  edm_qstat_t        q_stat,
  output logic              pop,
  output logic              out_valid,
  output logic [DIST_W-1:0] out_dist,
  input  logic              out_ready
);

  logic adv;
  logic out_valid_r;
  logic [DIST_W-1:0] dist_r;

  // Stage valid bits before the square root.
  logic v0_r, v1_r, v2_r, v3_r, v4_r, v5_r, v6_r, v7_r, v8_r;

  assign adv       = !out_valid_r || out_ready;
  assign pop       = adv && !q_stat.empty;
  assign out_valid = out_valid_r;
  assign out_dist  = dist_r;

  // Stage 0: magnitudes.
  logic [AY_W-1:0]    ay0_r, ay0_nxt;
  logic [ADLON_W-1:0] adlon0_r, adlon0_nxt;
  logic [MAG_W-1:0]   mag0_r, mag0_nxt;
  logic [DLON_W-1:0]  neg_dlon;
  logic [MEAN_W-1:0]  neg_mean;

  assign neg_dlon   = (~head_item.dlon) + DLON_W'(1);
  assign neg_mean   = (~head_item.mean) + MEAN_W'(1);
  assign ay0_nxt    = head_item.dlat[DLAT_W-1] ? (~head_item.dlat) + AY_W'(1)
                                               : head_item.dlat;
  assign adlon0_nxt = head_item.dlon[DLON_W-1] ? neg_dlon[ADLON_W-1:0]
                                               : head_item.dlon[ADLON_W-1:0];
  assign mag0_nxt   = head_item.mean[MEAN_W-1] ? neg_mean : head_item.mean;

  // Stage 1: whole degrees of the mean latitude and |dlon| / 10000.
  logic [MAG_W+DEG_RECIP_W-1:0]   deg_prod;
  logic [ADLON_W+Q_RECIP_W-1:0]   q_prod;
  logic [DEG_W-1:0]   deg1_r;
  logic [Q_W-1:0]     q1_r;
  logic [ADLON_W-1:0] adlon1_r;
  logic [AY_W-1:0]    ay1_r;

  assign deg_prod = mag0_r * DEG_RECIP;
  assign q_prod   = adlon0_r * Q_RECIP;

  // Stage 2: table index, fraction and the interpolation step.
  logic [DEG_W-1:0]  deg_c;
  logic [IDX_W-1:0]  idx;
  logic [FRAC_W-1:0] frac;
  logic [DEG_W-1:0]  idx_deg;
  logic [COS_W-1:0]  cos_base;
  logic [COS_W-1:0]  cos_next;
  logic [COS_W-1:0]  cos_diff;
  logic [COS_W+FRAC_W-1:0] step_prod;
  logic [31:0]       r_full;
  logic [R_W-1:0]    r2_r;
  logic [Q_W-1:0]    q2_r;
  logic [COS_W-1:0]  base2_r;
  logic [COS_W-1:0]  p2_r;
  logic [AY_W-1:0]   ay2_r;

  assign deg_c = (deg1_r > DEG_CLAMP) ? DEG_CLAMP : deg1_r;

  always_comb begin
    idx = '0;
    for (int k = 1; k <= TABLE_LAST; k++) begin
      if (deg_c >= DEG_W'(10 * k)) begin
        idx = IDX_W'(k);
      end
    end
  end

  assign idx_deg   = DEG_W'(idx) * DEG_W'(10);
  assign frac      = FRAC_W'(deg_c - idx_deg);
  assign cos_base  = edm_cos_point(idx);
  assign cos_next  = (idx == IDX_W'(TABLE_LAST)) ? cos_base
                                                  : edm_cos_point(idx + IDX_W'(1));
  assign cos_diff  = cos_base - cos_next;
  assign step_prod = cos_diff * frac;
  assign r_full    = 32'(adlon1_r) - 32'(q1_r) * COS_SCALE;

  // Stage 3: interpolated cosine.
  logic [COS_W+13-1:0] ten_prod;
  logic [COS_W-1:0]    c3_r;
  logic [R_W-1:0]      r3_r;
  logic [Q_W-1:0]      q3_r;
  logic [AY_W-1:0]     ay3_r;

  assign ten_prod = p2_r * TEN_RECIP;

  // Stage 4: quotient and remainder parts of |dlon| * cos.
  logic [2*R_W-1:0]     rc_prod;
  logic [Q_W+COS_W-1:0] qc_prod;
  logic [RC_W-1:0]      rc4_r;
  logic [QC_W-1:0]      qc4_r;
  logic [AY_W-1:0]      ay4_r;

  assign rc_prod = r3_r * c3_r;
  assign qc_prod = q3_r * c3_r;

  // Stage 5: remainder part divided by 10000.
  logic [RC_W+R_RECIP_W-1:0] f_prod;
  logic [R_W-1:0]   f5_r;
  logic [QC_W-1:0]  qc5_r;
  logic [AY_W-1:0]  ay5_r;

  assign f_prod = rc4_r * R_RECIP;

  // Stage 6: |dx|.
  logic [AX_W:0]    ax_sum;
  logic [AX_W-1:0]  ax6_r;
  logic [AY_W-1:0]  ay6_r;

  assign ax_sum = {1'b0, qc5_r} + (AX_W + 1)'(f5_r);

  // Stage 7: squares.
  logic [2*AX_W-1:0] axsq_prod;
  logic [2*AY_W-1:0] aysq_prod;
  logic [SUM_W-1:0]  axsq7_r;
  logic [SUM_W-1:0]  aysq7_r;

  assign axsq_prod = ax6_r * ax6_r;
  assign aysq_prod = ay6_r * ay6_r;

  // Stage 8: sum of squares.
  logic [SUM_W-1:0] sum8_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v0_r <= 1'b0;
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
      v6_r <= 1'b0;
      v7_r <= 1'b0;
      v8_r <= 1'b0;
    end else if (adv) begin
      v0_r <= pop;
      v1_r <= v0_r;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
      v6_r <= v5_r;
      v7_r <= v6_r;
      v8_r <= v7_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      ay0_r    <= ay0_nxt;
      adlon0_r <= adlon0_nxt;
      mag0_r   <= mag0_nxt;

      deg1_r   <= deg_prod[DEG_SHIFT +: DEG_W];
      q1_r     <= q_prod[Q_SHIFT +: Q_W];
      adlon1_r <= adlon0_r;
      ay1_r    <= ay0_r;

      r2_r     <= r_full[R_W-1:0];
      q2_r     <= q1_r;
      base2_r  <= cos_base;
      p2_r     <= step_prod[COS_W-1:0];
      ay2_r    <= ay1_r;

      c3_r     <= base2_r - COS_W'(ten_prod[TEN_SHIFT +: STEP_W]);
      r3_r     <= r2_r;
      q3_r     <= q2_r;
      ay3_r    <= ay2_r;

      rc4_r    <= rc_prod[RC_W-1:0];
      qc4_r    <= qc_prod[QC_W-1:0];
      ay4_r    <= ay3_r;

      f5_r     <= f_prod[R_SHIFT +: R_W];
      qc5_r    <= qc4_r;
      ay5_r    <= ay4_r;

      ax6_r    <= ax_sum[AX_W-1:0];
      ay6_r    <= ay5_r;

      axsq7_r  <= SUM_W'(axsq_prod);
      aysq7_r  <= aysq_prod[SUM_W-1:0];

      sum8_r   <= axsq7_r + aysq7_r;
    end
  end

  // Square root.
  logic              root_valid;
  logic [ROOT_W-1:0] root;

  edm_sqrt u_sqrt (
    .clk        (clk),
    .rst_n      (rst_n),
    .adv        (adv),
    .in_valid   (v8_r),
    .rad        ({1'b0, sum8_r}),
    .root_valid (root_valid),
    .root       (root)
  );

  // Meters scale: two partial products, then their sum and the final shift.
  logic                          vs_r;
  logic [ROOT_W+SCALE_LO_W-1:0]  plo_r;
  logic [ROOT_W+SCALE_HI_W-1:0]  phi_r;
  logic [SCALE_SUM_W-1:0]        scale_sum;

  assign scale_sum = SCALE_SUM_W'(plo_r) + (SCALE_SUM_W'(phi_r) << SCALE_LO_W);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vs_r        <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vs_r        <= root_valid;
      out_valid_r <= vs_r;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      plo_r  <= root * SCALE_LO;
      phi_r  <= root * SCALE_HI;
      dist_r <= scale_sum[SCALE_SHIFT +: DIST_W];
    end
  end

endmodule

`default_nettype wire
